[src/voxel_store_top_block_scan_defines.svh]
// Assertion macros shared by the voxel store checker.
`ifndef VOXEL_STORE_TOP_BLOCK_SCAN_DEFINES_SVH
`define VOXEL_STORE_TOP_BLOCK_SCAN_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define VSBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voxel store port check failed");

// Next-cycle implication, disabled while reset is held.
`define VSBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voxel store port check failed");

// Next-cycle implication that is also checked across reset.
`define VSBS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("voxel store reset check failed");

`endif

[src/vsbs_pkg.sv]
// Shared constants, codes and types of the voxel store.
package vsbs_pkg;

    localparam int SECTION_COUNT = 16;
    localparam int SEC_W         = 4;
    localparam int COORD_W       = 4;
    localparam int BYTE_W        = 8;
    localparam int NIB_W         = 4;
    localparam int CELL_ID_W     = BYTE_W + NIB_W;
    localparam int ID_W          = 16;
    localparam int ADDR_W        = SEC_W + 3 * COORD_W;
    localparam int STORE_DEPTH   = SECTION_COUNT * (1 << (3 * COORD_W));
    localparam int SCAN_W        = SEC_W + COORD_W;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [SCAN_W-1:0] SCAN_LAST  =
        SCAN_W'(SECTION_COUNT * (1 << COORD_W) - 1);

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_WR_LO = 2'd0;
    localparam t_mode MODE_WR_HI = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;
    localparam t_mode MODE_CLEAR = 2'd3;

    typedef struct packed {
        t_mode              mode;
        logic [SEC_W-1:0]   section_index;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [BYTE_W-1:0]  value_byte;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic wr_lo;
        logic wr_hi;
        logic scan_start;
        logic scan_rd;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

[src/vsbs_ctrl.sv]
// Controller state machine of the voxel store: clear pass, writes and column scan.
module vsbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  vsbs_pkg::t_mode i_mode,
    input  logic [3:0]      i_section_index,
    input  vsbs_pkg::t_status i_status,
    output logic            o_s_tready,
    output vsbs_pkg::t_cmd  o_cmd
);
    import vsbs_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       sec_ok;

    assign sec_ok = int'(i_section_index) < SECTION_COUNT;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    case (i_mode)
                        MODE_WR_LO: o_cmd.wr_lo = sec_ok;
                        MODE_WR_HI: o_cmd.wr_hi = sec_ok;
                        MODE_QUERY: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                        MODE_CLEAR: n_state = ST_CLEAR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last read word is compared in this cycle.
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/vsbs_datapath.sv]
// Datapath of the voxel store: cell memories, clear and scan counters, output register.
module vsbs_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vsbs_pkg::t_cmd                 i_cmd,
    input  vsbs_pkg::t_item                i_item,
    input  logic                           i_m_tready,
    output vsbs_pkg::t_status              o_status,
    output logic                           o_m_tvalid,
    output logic [vsbs_pkg::ID_W-1:0]      o_top_block,
    output logic                           o_found
);
    import vsbs_pkg::*;

    // Low byte and bits 11:8 live in separate memories, so each write mode
    // touches one memory and keeps the other part without a read.
    logic [BYTE_W-1:0] mem_lo [STORE_DEPTH];
    logic [NIB_W-1:0]  mem_hi [STORE_DEPTH];

    logic [ADDR_W-1:0]    r_clr_cnt;
    logic [SCAN_W-1:0]    r_scan_cnt;
    logic [COORD_W-1:0]   r_col_x;
    logic [COORD_W-1:0]   r_col_z;
    logic                 r_rd_valid;
    logic [BYTE_W-1:0]    r_rd_lo;
    logic [NIB_W-1:0]     r_rd_hi;
    logic [CELL_ID_W-1:0] r_top;
    logic                 r_found;
    logic                 r_out_valid;
    logic [CELL_ID_W-1:0] r_out_top;
    logic                 r_out_found;

    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [BYTE_W-1:0]    wr_lo_data;
    logic [NIB_W-1:0]     wr_hi_data;
    logic [NIB_W-1:0]     nibble;

    // Odd x takes the high nibble of the packed pair.
    assign nibble = i_item.cell_x[0] ? i_item.value_byte[BYTE_W-1:NIB_W]
                                     : i_item.value_byte[NIB_W-1:0];

    // Write port: the clearing pass writes zeros, otherwise the request cell.
    always_comb begin
        if (i_cmd.clear_wr) begin
            wr_addr    = r_clr_cnt;
            wr_lo_data = '0;
            wr_hi_data = '0;
        end else begin
            wr_addr    = {i_item.section_index, i_item.cell_x,
                          i_item.cell_y, i_item.cell_z};
            wr_lo_data = i_item.value_byte;
            wr_hi_data = nibble;
        end
    end

    // Scan read address: section and height come from the walk counter.
    assign rd_addr = {r_scan_cnt[SCAN_W-1:COORD_W], r_col_x,
                      r_scan_cnt[COORD_W-1:0], r_col_z};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr || i_cmd.wr_lo) begin
            mem_lo[wr_addr] <= wr_lo_data;
        end
        if (i_cmd.clear_wr || i_cmd.wr_hi) begin
            mem_hi[wr_addr] <= wr_hi_data;
        end
        r_rd_lo <= mem_lo[rd_addr];
        r_rd_hi <= mem_hi[rd_addr];
    end

    // Clearing pass counter, back at zero after each pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_wr) begin
            if (o_status.clear_last) begin
                r_clr_cnt <= '0;
            end else begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // Column walk from the lowest section and height upward.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_cnt <= '0;
            r_col_x    <= i_item.cell_x;
            r_col_z    <= i_item.cell_z;
        end else if (i_cmd.scan_rd) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_rd;
        end
    end

    // The last non-zero cell seen in the walk is the highest one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_top   <= '0;
            r_found <= 1'b0;
        end else if (r_rd_valid && ({r_rd_hi, r_rd_lo} != '0)) begin
            r_top   <= {r_rd_hi, r_rd_lo};
            r_found <= 1'b1;
        end
    end

    // Output register; it holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_top   <= r_top;
            r_out_found <= r_found;
        end
    end

    assign o_status.clear_last = (r_clr_cnt == CLEAR_LAST);
    assign o_status.scan_last  = (r_scan_cnt == SCAN_LAST);
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid  = r_out_valid;
    assign o_top_block = {{(ID_W - CELL_ID_W){1'b0}}, r_out_top};
    assign o_found     = r_out_found;

endmodule

[src/voxel_store_top_block_scan.sv]
// Voxel store of 16 sections of 16x16x16 cells with a top-block column query.
//
// Requests arrive on the slave stream (i_s_*). A request is taken when
// i_s_tvalid and o_s_tready are high at a rising edge of i_clk.
// Mode 0 writes a cell's low byte, mode 1 writes bits 11:8 from a packed
// nibble pair and clears bits 15:12; neither gives a result.
// Mode 2 walks the 256 cells of column (x,z), one memory read per cycle,
// and gives one result on the master stream (o_m_*): the highest non-zero
// id and a found flag. After the walk, a drain state covers the read port
// of the cell memory and the last compare, and the result is then loaded
// into the output register. The next request is taken in the cycle after
// the load at the earliest, so no request is taken while a query runs.
// Mode 3 clears the store in a pass over its 65536 cells, one cell per cycle,
// during which o_s_tready is low.
// After i_rst_n is released the same clearing pass runs before the first
// request is taken.
// A result waits in the output register while i_m_tready is low; writes are
// still taken, and a following query finishes its walk and then holds until
// the register is free.
module voxel_store_top_block_scan (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: mode[1:0], section_index[5:2], cell_x[9:6],
    // cell_y[13:10], cell_z[17:14], value_byte[25:18], zero fill.
    input  logic [vsbs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: top_block[15:0].
    output logic [vsbs_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // Fields from bit 0: found[0].
    output logic [0:0]  o_m_tuser
);
    import vsbs_pkg::*;

    t_item   item;
    t_cmd    cmd;
    t_status status;
    logic    found;

    // Unpack the request fields.
    assign item.mode          = i_s_tdata[1:0];
    assign item.section_index = i_s_tdata[5:2];
    assign item.cell_x        = i_s_tdata[9:6];
    assign item.cell_y        = i_s_tdata[13:10];
    assign item.cell_z        = i_s_tdata[17:14];
    assign item.value_byte    = i_s_tdata[25:18];

    vsbs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_mode          (item.mode),
        .i_section_index (item.section_index),
        .i_status        (status),
        .o_s_tready      (o_s_tready),
        .o_cmd           (cmd)
    );

    vsbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_m_tready  (i_m_tready),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .o_top_block (o_m_tdata),
        .o_found     (found)
    );

    assign o_m_tuser[0] = found;

endmodule

[src/vsbs_checker.sv]
// Port checker of the voxel store, bound to the top level.
`include "voxel_store_top_block_scan_defines.svh"

module vsbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [vsbs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [vsbs_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);
    import vsbs_pkg::*;

    logic                 out_stall;
    logic [OUT_TDATA_W:0] out_word;
    logic                 query_taken;

    // Result fields and handshake terms used by the checks.
    assign out_stall   = o_m_tvalid && !i_m_tready;
    assign out_word    = {o_m_tuser, o_m_tdata};
    assign query_taken = i_s_tvalid && o_s_tready && (i_s_tdata[1:0] == MODE_QUERY);

    // A stalled result keeps its fields.
    `VSBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(out_word))

    // The found flag and a non-zero id go together.
    `VSBS_ASSERT_NOW(a_found_match, i_clk, i_rst_n, o_m_tvalid, o_m_tuser[0] == (o_m_tdata != '0))

    // Bits 15:12 of a stored id are never set.
    `VSBS_ASSERT_NOW(a_top_nibble, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[15:12] == 4'h0)

    // Reset starts the clearing pass, so no request is taken right after it.
    `VSBS_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_s_tready)

    // A column query holds off the next request while the walk runs.
    `VSBS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, query_taken, !o_s_tready)

endmodule

bind voxel_store_top_block_scan vsbs_checker u_vsbs_checker (.*);
